>>> src/assert_macros.svh
// Assertion macros shared by the route update RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks a property on every rising clock edge outside reset.
`define DVRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`endif

>>> src/dvru_pkg.sv
// Types and constants of the distance-vector route update block.
// Used by the cell modules and the top level; depends on nothing.
`timescale 1ns / 1ps
package dvru_pkg;
  localparam int ROW_W  = 10;
  localparam int LROW_W = 6;

  localparam logic OP_INSTALL = 1'b0;
  localparam logic OP_ADVERT  = 1'b1;

  localparam logic [2:0] OUT_INSTALLED = 3'd0;
  localparam logic [2:0] OUT_IGNORED   = 3'd1;
  localparam logic [2:0] OUT_KEPT      = 3'd2;
  localparam logic [2:0] OUT_REFRESHED = 3'd3;
  localparam logic [2:0] OUT_REPLACED  = 3'd4;
  localparam logic [2:0] OUT_ADDED     = 3'd5;
  localparam logic [2:0] OUT_FULL      = 3'd6;

  localparam logic [7:0] HOP_MAX = 8'd255;

  typedef struct packed {
    logic        act;
    logic        matched;
    logic        refreshed;
    logic        replaced;
    logic [ROW_W-1:0] idx;
    logic [7:0]  hop;
  } rwave_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] nbr;
    logic [7:0]  newhop;
    logic [31:0] now;
  } rquery_t;

  typedef struct packed {
    logic        en;
    logic [ROW_W-1:0] idx;
    logic [31:0] dest;
    logic [31:0] mask;
    logic [31:0] next;
    logic [7:0]  hops;
    logic [7:0]  port;
    logic [31:0] stamp;
  } rwrite_t;

  typedef struct packed {
    logic act;
    logic hit;
  } lwave_t;

  typedef struct packed {
    logic        en;
    logic [LROW_W-1:0] idx;
    logic [31:0] net;
  } lwrite_t;
endpackage

>>> src/distance_vector_route_update.sv
// Top level of the distance-vector route update: controller, local and route cell rows.
// Depends on dvru_pkg, dvru_local_cell, dvru_route_cell and assert_macros.svh.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  op, address, net_mask, hop_count, ...
//   out_     output     out_valid/out_stall  outcome, entry_index, route_hop, ...
//
// An advertisement sends a query wave that moves one cell per cycle along the local row
// and then, unless a local subnet matched, along the route row.
// Reset empties both tables at once through the cell valid bits.
// A finished result waits in the output register while the next transaction is taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module distance_vector_route_update #(
  parameter int ROUTE_ENTRIES = 64,
  parameter int LOCAL_NETS    = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [31:0] in_address,
  input  logic [31:0] in_net_mask,
  input  logic [7:0]  in_hop_count,
  input  logic [31:0] in_neighbor_addr,
  input  logic [7:0]  in_port,
  input  logic [31:0] in_now,
  input  logic        in_last_in_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_outcome,
  output logic [5:0]  out_entry_index,
  output logic [7:0]  out_route_hop,
  output logic [6:0]  out_route_total,
  output logic        out_message_done
);
  import dvru_pkg::*;

  localparam int CW  = $clog2(ROUTE_ENTRIES + 1);
  localparam int LCW = $clog2(LOCAL_NETS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOCAL = 2'd1;
  localparam logic [1:0] S_ROUTE = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]     state_r, state_nxt;
  logic [CW-1:0]  route_cnt_r, route_cnt_nxt;
  logic [LCW-1:0] local_cnt_r, local_cnt_nxt;
  logic           lstart_r, lstart_nxt;
  logic           rstart_r, rstart_nxt;

  logic        q_op_r, q_last_r;
  logic [31:0] q_addr_r, q_mask_r, q_nbr_r, q_now_r;
  logic [7:0]  q_newhop_r, q_port_r;
  logic [31:0] q_net;

  logic [2:0]       res_outcome_r, res_outcome_nxt;
  logic [ROW_W-1:0] res_idx_r, res_idx_nxt;
  logic [7:0]       res_hop_r, res_hop_nxt;
  logic             res_rwr_r, res_rwr_nxt;
  logic             res_lwr_r, res_lwr_nxt;

  logic             out_valid_r;
  logic [2:0]       out_outcome_r;
  logic [5:0]       out_index_r;
  logic [7:0]       out_hop_r;
  logic [6:0]       out_total_r;
  logic             out_done_r;

  logic             accept;
  logic             fire;
  logic [CW-1:0]    cnt_after;
  logic [ROW_W:0]   cnt_ext;

  rquery_t q;
  rwrite_t rwr;
  lwrite_t lwr;
  rwave_t  rwave [0:ROUTE_ENTRIES];
  lwave_t  lwave [0:LOCAL_NETS];

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign fire = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  assign q_net = q_addr_r & q_mask_r;

  assign q.addr   = q_addr_r;
  assign q.nbr    = q_nbr_r;
  assign q.newhop = q_newhop_r;
  assign q.now    = q_now_r;

  always_comb begin
    rwave[0]     = '0;
    rwave[0].act = rstart_r;
    lwave[0]     = '0;
    lwave[0].act = lstart_r;
  end

  always_comb begin
    rwr       = '0;
    rwr.en    = fire && res_rwr_r;
    rwr.idx   = ROW_W'(route_cnt_r);
    rwr.mask  = q_mask_r;
    rwr.port  = q_port_r;
    if (q_op_r == OP_INSTALL) begin
      rwr.dest  = q_net;
      rwr.next  = q_net;
      rwr.hops  = 8'd1;
      rwr.stamp = 32'd0;
    end else begin
      rwr.dest  = q_addr_r;
      rwr.next  = q_nbr_r;
      rwr.hops  = q_newhop_r;
      rwr.stamp = q_now_r;
    end
    lwr     = '0;
    lwr.en  = fire && res_lwr_r;
    lwr.idx = LROW_W'(local_cnt_r);
    lwr.net = q_net;
  end

  for (genvar k = 0; k < LOCAL_NETS; k++) begin : g_local
    dvru_local_cell #(.K(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .q_net    (q_net),
      .wr       (lwr),
      .wave_in  (lwave[k]),
      .wave_out (lwave[k+1])
    );
  end

  for (genvar k = 0; k < ROUTE_ENTRIES; k++) begin : g_route
    dvru_route_cell #(.K(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .q        (q),
      .wr       (rwr),
      .wave_in  (rwave[k]),
      .wave_out (rwave[k+1])
    );
  end

  always_comb begin
    state_nxt       = state_r;
    lstart_nxt      = 1'b0;
    rstart_nxt      = 1'b0;
    res_outcome_nxt = res_outcome_r;
    res_idx_nxt     = res_idx_r;
    res_hop_nxt     = res_hop_r;
    res_rwr_nxt     = res_rwr_r;
    res_lwr_nxt     = res_lwr_r;
    route_cnt_nxt   = route_cnt_r;
    local_cnt_nxt   = local_cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_idx_nxt = '0;
          res_hop_nxt = '0;
          res_rwr_nxt = 1'b0;
          res_lwr_nxt = 1'b0;
          if (in_op == OP_INSTALL) begin
            state_nxt = S_DONE;
            if ((route_cnt_r >= CW'(ROUTE_ENTRIES)) || (local_cnt_r >= LCW'(LOCAL_NETS))) begin
              res_outcome_nxt = OUT_FULL;
            end else begin
              res_outcome_nxt = OUT_INSTALLED;
              res_idx_nxt     = ROW_W'(route_cnt_r);
              res_hop_nxt     = 8'd1;
              res_rwr_nxt     = 1'b1;
              res_lwr_nxt     = 1'b1;
            end
          end else begin
            state_nxt  = S_LOCAL;
            lstart_nxt = 1'b1;
          end
        end
      end
      S_LOCAL: begin
        if (lwave[LOCAL_NETS].act) begin
          if (lwave[LOCAL_NETS].hit) begin
            res_outcome_nxt = OUT_IGNORED;
            state_nxt       = S_DONE;
          end else begin
            rstart_nxt = 1'b1;
            state_nxt  = S_ROUTE;
          end
        end
      end
      S_ROUTE: begin
        if (rwave[ROUTE_ENTRIES].act) begin
          state_nxt   = S_DONE;
          res_idx_nxt = rwave[ROUTE_ENTRIES].idx;
          res_hop_nxt = rwave[ROUTE_ENTRIES].hop;
          if (rwave[ROUTE_ENTRIES].replaced) begin
            res_outcome_nxt = OUT_REPLACED;
          end else if (rwave[ROUTE_ENTRIES].refreshed) begin
            res_outcome_nxt = OUT_REFRESHED;
          end else if (rwave[ROUTE_ENTRIES].matched) begin
            res_outcome_nxt = OUT_KEPT;
          end else if (route_cnt_r >= CW'(ROUTE_ENTRIES)) begin
            res_outcome_nxt = OUT_FULL;
            res_idx_nxt     = '0;
            res_hop_nxt     = '0;
          end else begin
            res_outcome_nxt = OUT_ADDED;
            res_idx_nxt     = ROW_W'(route_cnt_r);
            res_hop_nxt     = q_newhop_r;
            res_rwr_nxt     = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (fire) begin
          state_nxt = S_IDLE;
          if (res_rwr_r) begin
            route_cnt_nxt = route_cnt_r + CW'(1);
          end
          if (res_lwr_r) begin
            local_cnt_nxt = local_cnt_r + LCW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign cnt_after = res_rwr_r ? (route_cnt_r + CW'(1)) : route_cnt_r;
  assign cnt_ext   = (ROW_W+1)'(cnt_after);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      route_cnt_r <= '0;
      local_cnt_r <= '0;
      lstart_r    <= 1'b0;
      rstart_r    <= 1'b0;
      res_rwr_r   <= 1'b0;
      res_lwr_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      route_cnt_r <= route_cnt_nxt;
      local_cnt_r <= local_cnt_nxt;
      lstart_r    <= lstart_nxt;
      rstart_r    <= rstart_nxt;
      res_rwr_r   <= res_rwr_nxt;
      res_lwr_r   <= res_lwr_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_outcome_r <= res_outcome_nxt;
    res_idx_r     <= res_idx_nxt;
    res_hop_r     <= res_hop_nxt;
    if (accept) begin
      q_op_r     <= in_op;
      q_addr_r   <= in_address;
      q_mask_r   <= in_net_mask;
      q_nbr_r    <= in_neighbor_addr;
      q_newhop_r <= (in_hop_count == HOP_MAX) ? HOP_MAX : (in_hop_count + 8'd1);
      q_port_r   <= in_port;
      q_now_r    <= in_now;
      q_last_r   <= in_last_in_message;
    end
    if (fire) begin
      out_outcome_r <= res_outcome_r;
      out_index_r   <= res_idx_r[5:0];
      out_hop_r     <= res_hop_r;
      out_total_r   <= cnt_ext[6:0];
      out_done_r    <= q_last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_outcome      = out_outcome_r;
  assign out_entry_index  = out_index_r;
  assign out_route_hop    = out_hop_r;
  assign out_route_total  = out_total_r;
  assign out_message_done = out_done_r;

  `DVRU_ASSERT(a_count_bound, route_cnt_r <= CW'(ROUTE_ENTRIES), "route count beyond table")
  `DVRU_ASSERT(a_count_step, (route_cnt_r != $past(route_cnt_r)) |-> (route_cnt_r == $past(route_cnt_r) + CW'(1)), "route count jumped")
  `DVRU_ASSERT(a_result_src, (!$past(out_valid_r) && out_valid_r) |-> ($past(state_r) == S_DONE), "result without a finished transaction")
endmodule

>>> src/dvru_local_cell.sv
// One local-subnet cell: holds a masked subnet and checks the passing query.
// Depends on dvru_pkg.
`timescale 1ns / 1ps
module dvru_local_cell #(
  parameter int K = 0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [31:0]      q_net,
  input  dvru_pkg::lwrite_t wr,
  input  dvru_pkg::lwave_t wave_in,
  output dvru_pkg::lwave_t wave_out
);
  import dvru_pkg::*;

  logic        valid_r;
  logic [31:0] net_r;
  lwave_t      wave_r;
  lwave_t      wave_nxt;

  always_comb begin
    wave_nxt = wave_in;
    if (wave_in.act && valid_r && (net_r == q_net)) begin
      wave_nxt.hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      wave_r  <= '0;
    end else begin
      wave_r <= wave_nxt;
      if (wr.en && (wr.idx == LROW_W'(K))) begin
        valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == LROW_W'(K))) begin
      net_r <= wr.net;
    end
  end

  assign wave_out = wave_r;
endmodule

>>> src/dvru_route_cell.sv
// One route cell: holds a route entry and applies the passing advertisement.
// Depends on dvru_pkg.
`timescale 1ns / 1ps
module dvru_route_cell #(
  parameter int K = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dvru_pkg::rquery_t q,
  input  dvru_pkg::rwrite_t wr,
  input  dvru_pkg::rwave_t  wave_in,
  output dvru_pkg::rwave_t  wave_out
);
  import dvru_pkg::*;

  logic        valid_r;
  logic        up_r;
  logic [31:0] dest_r;
  logic [31:0] mask_r;
  logic [31:0] next_r;
  logic [7:0]  hops_r;
  logic [7:0]  port_r;
  logic [31:0] time_r;
  rwave_t      wave_r;
  rwave_t      wave_nxt;
  logic        hit;
  logic        do_refresh;
  logic        do_replace;
  logic        wr_here;

  assign wr_here    = wr.en && (wr.idx == ROW_W'(K));
  assign hit        = wave_in.act && !wave_in.replaced && valid_r && (dest_r == q.addr);
  assign do_refresh = hit && up_r && (next_r == q.nbr);
  assign do_replace = hit && !do_refresh && (!up_r || (q.newhop < hops_r));

  always_comb begin
    wave_nxt = wave_in;
    if (hit) begin
      wave_nxt.matched = 1'b1;
      if (do_replace) begin
        wave_nxt.replaced = 1'b1;
        wave_nxt.idx      = ROW_W'(K);
        wave_nxt.hop      = q.newhop;
      end else if (do_refresh && !wave_in.refreshed) begin
        wave_nxt.refreshed = 1'b1;
        wave_nxt.idx       = ROW_W'(K);
        wave_nxt.hop       = hops_r;
      end else if (!do_refresh && !wave_in.matched) begin
        wave_nxt.idx = ROW_W'(K);
        wave_nxt.hop = hops_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      up_r    <= 1'b0;
      wave_r  <= '0;
    end else begin
      wave_r <= wave_nxt;
      if (wr_here) begin
        valid_r <= 1'b1;
        up_r    <= 1'b1;
      end else if (do_replace) begin
        up_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      dest_r <= wr.dest;
      mask_r <= wr.mask;
      next_r <= wr.next;
      hops_r <= wr.hops;
      port_r <= wr.port;
      time_r <= wr.stamp;
    end else if (do_replace) begin
      next_r <= q.nbr;
      hops_r <= q.newhop;
      time_r <= q.now;
    end else if (do_refresh) begin
      time_r <= q.now;
    end
  end

  assign wave_out = wave_r;
endmodule

>>> bench/tb_top.sv
// Testbench of the distance-vector route update block: directed table, then random traffic.
// Depends on dvru_pkg and distance_vector_route_update; checks each result with a predictor.
`timescale 1ns / 1ps
module tb_top;
  import dvru_pkg::*;

  localparam int NROUTE = 64;
  localparam int NLOCAL = 8;
  localparam int NRAND = 930;
  localparam int LIMIT = 4000000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic in_op, in_last_in_message, out_message_done;
  logic [31:0] in_address, in_net_mask, in_neighbor_addr, in_now;
  logic [7:0] in_hop_count, in_port, out_route_hop;
  logic [2:0] out_outcome;
  logic [5:0] out_entry_index;
  logic [6:0] out_route_total;

  distance_vector_route_update dut (.*);

  typedef struct packed {
    logic        op;
    logic [31:0] address;
    logic [31:0] net_mask;
    logic [7:0]  hop_count;
    logic [31:0] neighbor;
    logic [7:0]  port;
    logic [31:0] stamp;
    logic        last;
  } advert_t;

  typedef struct packed {
    logic [2:0] outcome;
    logic [5:0] index;
    logic [7:0] hop;
    logic [6:0] total;
    logic       done;
  } verdict_t;

  typedef struct {
    advert_t  a;
    logic     fixed;
    verdict_t v;
  } row_t;

  logic [31:0] rt_dest [NROUTE];
  logic [31:0] rt_next [NROUTE];
  logic [7:0]  rt_hops [NROUTE];
  logic        rt_up [NROUTE];
  int          rt_count;
  logic [31:0] lc_net [NLOCAL];
  logic [31:0] lc_mask [NLOCAL];
  int          lc_count;

  verdict_t pending_verdicts[$];
  int failures = 0;
  int cycles = 0;
  bit stim_done = 0;
  logic [31:0] dest_pool [8];
  logic [31:0] nbr_pool [4];

  function automatic verdict_t update_routes(advert_t a);
    verdict_t v;
    logic [31:0] net;
    logic [7:0] nh;
    bit local_hit, matched, refreshed, replaced;
    int fm, fr, rp;
    net = a.address & a.net_mask;
    v = '0;
    v.done = a.last;
    local_hit = 0; matched = 0; refreshed = 0; replaced = 0;
    fm = 0; fr = 0; rp = 0;
    if (a.op == OP_INSTALL) begin
      if (rt_count >= NROUTE || lc_count >= NLOCAL) begin
        v.outcome = OUT_FULL;
      end else begin
        rt_dest[rt_count] = net;
        rt_next[rt_count] = net;
        rt_hops[rt_count] = 8'd1;
        rt_up[rt_count] = 1'b1;
        v.index = 6'(rt_count);
        v.hop = 8'd1;
        rt_count++;
        lc_net[lc_count] = net;
        lc_mask[lc_count] = a.net_mask;
        lc_count++;
        v.outcome = OUT_INSTALLED;
      end
    end else begin
      for (int j = 0; j < lc_count; j++)
        if ((lc_net[j] & lc_mask[j]) == net) local_hit = 1;
      if (local_hit) begin
        v.outcome = OUT_IGNORED;
      end else begin
        nh = (a.hop_count == 8'd255) ? 8'd255 : a.hop_count + 8'd1;
        for (int k = 0; k < rt_count && !replaced; k++) begin
          if (rt_dest[k] == a.address) begin
            if (!matched) begin
              matched = 1; fm = k;
            end
            if (rt_up[k] && rt_next[k] == a.neighbor) begin
              if (!refreshed) begin
                refreshed = 1; fr = k;
              end
            end else if (!rt_up[k] || nh < rt_hops[k]) begin
              rt_next[k] = a.neighbor;
              rt_hops[k] = nh;
              rt_up[k] = 1'b1;
              replaced = 1; rp = k;
            end
          end
        end
        if (replaced) begin
          v.outcome = OUT_REPLACED; v.index = 6'(rp); v.hop = rt_hops[rp];
        end else if (refreshed) begin
          v.outcome = OUT_REFRESHED; v.index = 6'(fr); v.hop = rt_hops[fr];
        end else if (matched) begin
          v.outcome = OUT_KEPT; v.index = 6'(fm); v.hop = rt_hops[fm];
        end else if (rt_count >= NROUTE) begin
          v.outcome = OUT_FULL;
        end else begin
          rt_dest[rt_count] = a.address;
          rt_next[rt_count] = a.neighbor;
          rt_hops[rt_count] = nh;
          rt_up[rt_count] = 1'b1;
          v.outcome = OUT_ADDED; v.index = 6'(rt_count); v.hop = nh;
          rt_count++;
        end
      end
    end
    v.total = 7'(rt_count);
    return v;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 120);
  endfunction

  function automatic advert_t random_advert();
    advert_t a;
    int r;
    a.op = ($urandom_range(0, 29) == 0) ? OP_INSTALL : OP_ADVERT;
    r = $urandom_range(0, 9);
    a.address = (r < 8) ? dest_pool[$urandom_range(0, 7)] : $urandom;
    a.net_mask = ($urandom_range(0, 3) == 0) ? $urandom : 32'hFFFFFF00;
    r = $urandom_range(0, 9);
    a.hop_count = (r == 0) ? 8'd254 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 15));
    a.neighbor = ($urandom_range(0, 7) == 0) ? $urandom : nbr_pool[$urandom_range(0, 3)];
    a.port = 8'($urandom);
    a.stamp = $urandom;
    a.last = 1'($urandom);
    return a;
  endfunction

  task automatic send(advert_t a);
    in_valid <= 1'b1;
    in_op <= a.op;
    in_address <= a.address;
    in_net_mask <= a.net_mask;
    in_hop_count <= a.hop_count;
    in_neighbor_addr <= a.neighbor;
    in_port <= a.port;
    in_now <= a.stamp;
    in_last_in_message <= a.last;
    do @(posedge clk); while (in_stall);
    pending_verdicts.push_back(update_routes(a));
  endtask

  task automatic pause_input();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    row_t rows[$];
    row_t rw;
    verdict_t got;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = 1'b0; in_address = '0; in_net_mask = '0; in_hop_count = '0;
    in_neighbor_addr = '0; in_port = '0; in_now = '0; in_last_in_message = 1'b0;
    rt_count = 0; lc_count = 0;
    for (int i = 0; i < NROUTE; i++) begin
      rt_dest[i] = '0; rt_next[i] = '0; rt_hops[i] = '0; rt_up[i] = 1'b0;
    end
    for (int i = 0; i < 8; i++) dest_pool[i] = {8'd20, 8'(i), 16'h0100};
    for (int i = 0; i < 4; i++) nbr_pool[i] = {8'd172, 16'h0, 8'(i + 1)};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: expected values typed in where obvious, else predicted.
    rows.push_back('{'{OP_ADVERT, 32'h0A000001, 32'hFFFFFF00, 8'd0, 32'h01010101, 8'd0,
      32'd0, 1'b1}, 1'b1, '{OUT_ADDED, 6'd0, 8'd1, 7'd1, 1'b1}});
    rows.push_back('{'{OP_INSTALL, 32'hC0A801FF, 32'hFFFFFF00, 8'd0, 32'h0, 8'd255,
      32'hFFFFFFFF, 1'b0}, 1'b1, '{OUT_INSTALLED, 6'd1, 8'd1, 7'd2, 1'b0}});
    rows.push_back('{'{OP_ADVERT, 32'hC0A80123, 32'hFFFFFF00, 8'd3, 32'h2, 8'd1,
      32'd5, 1'b1}, 1'b1, '{OUT_IGNORED, 6'd0, 8'd0, 7'd2, 1'b1}});
    rows.push_back('{'{OP_ADVERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd254, 32'hFFFFFFFF,
      8'd255, 32'hFFFFFFFF, 1'b0}, 1'b1, '{OUT_ADDED, 6'd2, 8'd255, 7'd3, 1'b0}});
    rows.push_back('{'{OP_ADVERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd255, 32'h0, 8'd0,
      32'd7, 1'b1}, 1'b1, '{OUT_KEPT, 6'd2, 8'd255, 7'd3, 1'b1}});
    rows.push_back('{'{OP_ADVERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd0, 32'h0, 8'd0,
      32'd8, 1'b0}, 1'b0, '0});
    rows.push_back('{'{OP_ADVERT, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'd9, 32'h0, 8'd0,
      32'd9, 1'b0}, 1'b0, '0});
    rows.push_back('{'{OP_ADVERT, 32'h0A000001, 32'hFFFFFF00, 8'd5, 32'h01010101, 8'd3,
      32'd10, 1'b0}, 1'b0, '0});
    rows.push_back('{'{OP_ADVERT, 32'h0A000001, 32'h0, 8'd0, 32'h0, 8'd3,
      32'd11, 1'b1}, 1'b0, '0});
    for (int i = 0; i < 7; i++)
      rows.push_back('{'{OP_INSTALL, {8'd30, 8'(i), 16'h0}, 32'hFFFF0000, 8'd0, 32'h0,
        8'(i), 32'd0, 1'b0}, 1'b0, '0});
    rows.push_back('{'{OP_INSTALL, 32'h55555555, 32'hFFFFFFFF, 8'd0, 32'h0, 8'd0,
      32'd0, 1'b1}, 1'b1, '{OUT_FULL, 6'd0, 8'd0, 7'd10, 1'b1}});
    rows.push_back('{'{OP_ADVERT, 32'h0, 32'h0, 8'd1, 32'h7, 8'd0, 32'd1, 1'b0}, 1'b0, '0});

    foreach (rows[i]) begin
      rw = rows[i];
      if (rw.fixed) begin
        got = update_routes(rw.a);
        if (got !== rw.v) begin
          $display("%0t directed row %0d: table %h, predictor %h", $time, i, rw.v, got);
          failures++;
        end
      end
      in_valid <= 1'b1;
      in_op <= rw.a.op; in_address <= rw.a.address; in_net_mask <= rw.a.net_mask;
      in_hop_count <= rw.a.hop_count; in_neighbor_addr <= rw.a.neighbor;
      in_port <= rw.a.port; in_now <= rw.a.stamp; in_last_in_message <= rw.a.last;
      do @(posedge clk); while (in_stall);
      if (rw.fixed) pending_verdicts.push_back(rw.v);
      else pending_verdicts.push_back(update_routes(rw.a));
      pause_input();
    end

    // Random traffic fills the table to the full state partway through.
    for (int n = 0; n < NRAND; n++) begin
      send(random_advert());
      pause_input();
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  initial begin
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      int g;
      @(posedge clk);
      g = gap_len();
      if ($urandom_range(0, 1) == 0) g = 0;
      out_stall <= (g > 0);
      if (g > 0) begin
        repeat (g - 1) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $display("%0t unexpected transaction: outcome %0d", $time, out_outcome);
        failures++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_outcome !== want.outcome || out_entry_index !== want.index ||
            out_route_hop !== want.hop || out_route_total !== want.total ||
            out_message_done !== want.done) begin
          $display("%0t mismatch: expected %0d/%0d/%0d/%0d/%0d, actual %0d/%0d/%0d/%0d/%0d",
            $time, want.outcome, want.index, want.hop, want.total, want.done,
            out_outcome, out_entry_index, out_route_hop, out_route_total,
            out_message_done);
          failures++;
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_verdicts.size() != 0 && cycles < LIMIT) @(posedge clk);
    repeat (200) @(posedge clk);
    if (failures == 0 && pending_verdicts.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("%0t timeout", $time);
      $display("*** FAILED ***");
      $finish;
    end
  end
endmodule
